[design/rfc_pkg.sv]
// rfc_pkg: shared types, constants and codes for the rectangle fill chunk generator
// no dependencies; imported by rfc_front, rfc_queue, rfc_back and the top level

package rfc_pkg;

	localparam int COORD_W          = 9;
	localparam int COLOR_IN_W       = 24;
	localparam int COLOR_OUT_W      = 16;
	localparam int PIXCNT_W         = 13;
	localparam int STATUS_W         = 2;
	localparam int PD_W             = 18;
	localparam int S_TDATA_W        = 64;
	localparam int M_TDATA_W        = 72;
	localparam int CHUNK_PIXELS_DEF = 5120;
	localparam int QUEUE_DEPTH_DEF  = 2;
	localparam int MAX_RESULTS      = 64;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_CHUNK  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

	// command kinds handed from front to back
	localparam logic [1:0] KIND_FILL   = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	// register indexes on the config port
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]             kind;
		logic [COLOR_OUT_W-1:0] color_rgb565;
		logic [COORD_W-1:0]     rect_x;
		logic [COORD_W-1:0]     rect_width;
		logic [COORD_W-1:0]     rect_y;
		logic [COORD_W-1:0]     rect_height;
	} rfc_cmd_t;

	function automatic logic [COLOR_OUT_W-1:0] to_565(input logic [COLOR_IN_W-1:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

[design/rect_fill_chunk_generator.sv]
// rect_fill_chunk_generator: top level, config registers plus front, queue and back
// depends on rfc_pkg, rfc_front, rfc_queue, rfc_back
//
//   group   dir  handshake          payload
//   s_*     in   s_tvalid/s_tready  s_tdata: fill request word
//   m_*     out  m_tvalid/m_tready  m_tdata: chunk window, count, color; m_tuser status;
//                                   m_tlast last result of a request
//   apb     in   psel/penable       screen_width at 0x0, screen_height at 0x4
//
// a fill request first passes through the width divider, then emits one chunk a cycle
// while m_tready stays high and the result budget of the word lasts.
// rejected and empty requests give their single result in the cycle after leaving the queue.
// at most 64 chunks per request word; a longer fill resumes on the next word taken.
// the front and its queue keep taking words while the back is busy or stalled, until they are full.
// reset clears all handshake state and sets the screen size to 240 x 320.

module rect_fill_chunk_generator #(
	parameter int CHUNK_PIXELS = rfc_pkg::CHUNK_PIXELS_DEF,
	parameter int QUEUE_DEPTH  = rfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// color_rgb888 24, rect_x 9, rect_width 9, rect_y 9, rect_height 9, zero pad 4
	input  logic [rfc_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// win_x_first 9, win_x_last 9, win_y_first 9, win_y_last 9, pixel_count 13,
	// color_rgb565 16, zero pad 7
	output logic [rfc_pkg::M_TDATA_W-1:0] m_tdata,
	// status 2
	output logic [rfc_pkg::STATUS_W-1:0]  m_tuser,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rfc_pkg::*;

	logic [COORD_W-1:0] screen_width_q;
	logic [COORD_W-1:0] screen_height_q;
	logic               reg_wr;
	logic               f_valid;
	logic               f_ready;
	rfc_cmd_t           f_cmd;
	logic               b_valid;
	logic               b_ready;
	rfc_cmd_t           b_cmd;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= COORD_W'(240);
			screen_height_q <= COORD_W'(320);
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[COORD_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[COORD_W-1:0];
				default:           screen_width_q  <= screen_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = {{(32 - COORD_W){1'b0}}, screen_width_q};
			REG_SCREEN_HEIGHT: prdata = {{(32 - COORD_W){1'b0}}, screen_height_q};
			default:           prdata = '0;
		endcase
	end

	rfc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.cmd_valid     (f_valid),
		.cmd_ready     (f_ready),
		.cmd           (f_cmd)
	);

	rfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	rfc_back #(
		.CHUNK_PIXELS (CHUNK_PIXELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (b_valid),
		.cmd_ready     (b_ready),
		.cmd           (b_cmd),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

endmodule

[design/rfc_queue.sv]
// rfc_queue: small register fifo of classified commands between front and back
// depends on rfc_pkg (rfc_cmd_t)

module rfc_queue #(
	parameter int DEPTH = rfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rfc_pkg::rfc_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rfc_pkg::rfc_cmd_t pop_data
);
	import rfc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

	rfc_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/rfc_front.sv]
// rfc_front: accepts fill requests, converts the color and classifies the rectangle
// depends on rfc_pkg (rfc_cmd_t, kind codes, to_565)

module rfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// color_rgb888 24, rect_x 9, rect_width 9, rect_y 9, rect_height 9, zero pad 4
	input  logic [rfc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [rfc_pkg::COORD_W-1:0]   screen_width,
	input  logic [rfc_pkg::COORD_W-1:0]   screen_height,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output rfc_pkg::rfc_cmd_t             cmd
);
	import rfc_pkg::*;

	logic [COLOR_IN_W-1:0] in_color;
	logic [COORD_W-1:0]    in_x;
	logic [COORD_W-1:0]    in_w;
	logic [COORD_W-1:0]    in_y;
	logic [COORD_W-1:0]    in_h;
	logic [COORD_W:0]      x_end;
	logic [COORD_W:0]      y_end;
	logic                  off_screen;
	logic                  empty_rect;
	rfc_cmd_t              cmd_nx;
	rfc_cmd_t              cmd_s1;
	logic                  vld_s1;

	assign in_color = s_tdata[23:0];
	assign in_x     = s_tdata[32:24];
	assign in_w     = s_tdata[41:33];
	assign in_y     = s_tdata[50:42];
	assign in_h     = s_tdata[59:51];

	assign x_end      = {1'b0, in_x} + {1'b0, in_w};
	assign y_end      = {1'b0, in_y} + {1'b0, in_h};
	assign off_screen = (x_end > {1'b0, screen_width}) || (y_end > {1'b0, screen_height});
	assign empty_rect = (in_w == '0) || (in_h == '0);

	always_comb begin
		cmd_nx.color_rgb565 = to_565(in_color);
		cmd_nx.rect_x       = in_x;
		cmd_nx.rect_width   = in_w;
		cmd_nx.rect_y       = in_y;
		cmd_nx.rect_height  = in_h;
		// off-screen check takes priority over the empty check
		if (off_screen) begin
			cmd_nx.kind = KIND_REJECT;
		end else if (empty_rect) begin
			cmd_nx.kind = KIND_EMPTY;
		end else begin
			cmd_nx.kind = KIND_FILL;
		end
	end

	assign s_tready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

endmodule

[design/rfc_back.sv]
// rfc_back: carries out queued commands, walks the fill in chunks and drives the result word
// depends on rfc_pkg (rfc_cmd_t, kind and status codes, widths)

module rfc_back #(
	parameter int CHUNK_PIXELS = rfc_pkg::CHUNK_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  rfc_pkg::rfc_cmd_t             cmd,
	input  logic [rfc_pkg::COORD_W-1:0]   screen_width,
	input  logic [rfc_pkg::COORD_W-1:0]   screen_height,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// win_x_first 9, win_x_last 9, win_y_first 9, win_y_last 9, pixel_count 13,
	// color_rgb565 16, zero pad 7
	output logic [rfc_pkg::M_TDATA_W-1:0] m_tdata,
	// status 2
	output logic [rfc_pkg::STATUS_W-1:0]  m_tuser,
	output logic                          m_tlast
);
	import rfc_pkg::*;

	localparam int CW   = $clog2(CHUNK_PIXELS + 1);
	localparam int DCW  = $clog2(CW + 1);
	localparam int RCW  = $clog2(MAX_RESULTS);
	localparam logic [CW-1:0]   DIVIDEND = CW'(CHUNK_PIXELS);
	localparam logic [PD_W-1:0] CHUNK_C  = PD_W'(CHUNK_PIXELS);
	localparam logic [DCW-1:0]  DIV_LAST = DCW'(CW - 1);
	localparam logic [RCW-1:0]  RES_LAST = RCW'(MAX_RESULTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0]             state_q;
	logic [COLOR_OUT_W-1:0] color_q;
	logic [COORD_W-1:0]     x_q;
	logic [COORD_W-1:0]     w_q;
	logic [COORD_W-1:0]     y_q;
	logic [COORD_W-1:0]     h_q;
	logic [PD_W-1:0]        total_q;
	logic [PD_W-1:0]        pd_q;
	logic [COORD_W-1:0]     col_q;
	logic [COORD_W-1:0]     row_q;
	logic [CW-1:0]          dvd_q;
	logic [CW-1:0]          qt_q;
	logic [COORD_W-1:0]     rm_q;
	logic [DCW-1:0]         div_cnt_q;
	logic [RCW-1:0]         res_cnt_q;

	logic                   out_vld_q;
	logic [M_TDATA_W-1:0]   out_data_q;
	logic [STATUS_W-1:0]    out_stat_q;
	logic                   out_last_q;

	logic                   load_ok;
	logic [COORD_W:0]       rem_try;
	logic                   rem_ge;
	logic                   col_zero;
	logic [PD_W-1:0]        npix_raw;
	logic [PD_W-1:0]        npix;
	logic [PD_W-1:0]        pd_nx;
	logic                   is_last;
	logic [COORD_W:0]       x1;
	logic [COORD_W:0]       y1;
	logic [COORD_W+1:0]     xl_full;
	logic [COORD_W+1:0]     yl_full;
	logic [COORD_W-1:0]     xlim;
	logic [COORD_W-1:0]     ylim;
	logic [COORD_W-1:0]     xl;
	logic [COORD_W-1:0]     yl;
	logic [M_TDATA_W-1:0]   chunk_data;
	logic                   status_pop;
	logic                   emit;

	assign load_ok = !out_vld_q || m_tready;

	always_comb begin
		unique case (state_q)
			S_IDLE:  cmd_ready = (cmd.kind == KIND_FILL) || load_ok;
			S_HOLD:  cmd_ready = 1'b1;
			default: cmd_ready = 1'b0;
		endcase
	end

	// restoring divide of the chunk size by the rectangle width, one bit a cycle
	assign rem_try = {rm_q, dvd_q[CW-1]};
	assign rem_ge  = (rem_try >= {1'b0, w_q});

	// chunk arithmetic
	assign col_zero = (col_q == '0);
	assign npix_raw = col_zero ? (total_q - pd_q) : PD_W'(w_q - col_q);
	assign npix     = (npix_raw > CHUNK_C) ? CHUNK_C : npix_raw;
	assign pd_nx    = pd_q + npix;
	assign is_last  = (pd_nx >= total_q);

	assign x1      = {1'b0, x_q} + {1'b0, col_q};
	assign y1      = {1'b0, y_q} + {1'b0, row_q};
	assign xl_full = {1'b0, x1} + {2'b0, w_q} - 1'b1;
	assign yl_full = {1'b0, y1} + {2'b0, h_q} - 1'b1;
	assign xlim    = (screen_width == '0) ? '0 : screen_width - 1'b1;
	assign ylim    = (screen_height == '0) ? '0 : screen_height - 1'b1;
	assign xl      = (xl_full > {2'b0, xlim}) ? xlim : xl_full[COORD_W-1:0];
	assign yl      = (yl_full > {2'b0, ylim}) ? ylim : yl_full[COORD_W-1:0];

	assign chunk_data = {7'b0, color_q, npix[PIXCNT_W-1:0], yl, y1[COORD_W-1:0], xl,
		x1[COORD_W-1:0]};

	assign status_pop = (state_q == S_IDLE) && cmd_valid && cmd_ready && (cmd.kind != KIND_FILL);
	assign emit       = (state_q == S_RUN) && load_ok;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.kind == KIND_FILL) begin
			color_q <= cmd.color_rgb565;
			x_q     <= cmd.rect_x;
			w_q     <= cmd.rect_width;
			y_q     <= cmd.rect_y;
			h_q     <= cmd.rect_height;
			total_q <= {{(PD_W - COORD_W){1'b0}}, cmd.rect_width}
				* {{(PD_W - COORD_W){1'b0}}, cmd.rect_height};
			pd_q    <= '0;
			col_q   <= '0;
			row_q   <= '0;
			dvd_q   <= DIVIDEND;
			qt_q    <= '0;
			rm_q    <= '0;
		end else if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[CW-2:0], 1'b0};
			qt_q  <= {qt_q[CW-2:0], rem_ge};
			rm_q  <= rem_ge ? COORD_W'(rem_try - {1'b0, w_q}) : rem_try[COORD_W-1:0];
		end else if (emit) begin
			pd_q <= pd_nx;
			if (col_zero) begin
				// a full chunk from the left edge moves on by whole rows plus the remainder
				row_q <= COORD_W'(row_q + qt_q);
				col_q <= rm_q;
			end else if (npix_raw <= CHUNK_C) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
			end else begin
				col_q <= COORD_W'(col_q + CHUNK_PIXELS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status_pop) begin
			out_data_q <= '0;
			out_stat_q <= (cmd.kind == KIND_REJECT) ? STAT_REJECT : STAT_EMPTY;
			out_last_q <= 1'b1;
		end else if (emit) begin
			out_data_q <= chunk_data;
			out_stat_q <= STAT_CHUNK;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			res_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (status_pop || emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.kind == KIND_FILL) begin
						state_q   <= S_DIV;
						div_cnt_q <= '0;
						res_cnt_q <= '0;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (emit) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else if (res_cnt_q == RES_LAST) begin
							// result budget for this word used up: wait for the next word
							state_q   <= S_HOLD;
							res_cnt_q <= '0;
						end else begin
							res_cnt_q <= res_cnt_q + 1'b1;
						end
					end
				end
				S_HOLD: begin
					// the word taken here only resumes the fill, its payload is dropped
					if (cmd_valid) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for rect_fill_chunk_generator, driving fill request words
// and apb screen-size writes, predicting every chunk result in a local model of the fill
// depends on rfc_pkg and rect_fill_chunk_generator
`timescale 1ns / 100ps

module tb_top;
	import rfc_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [COORD_W-1:0]     x_first;
		logic [COORD_W-1:0]     x_last;
		logic [COORD_W-1:0]     y_first;
		logic [COORD_W-1:0]     y_last;
		logic [PIXCNT_W-1:0]    pixel_count;
		logic [COLOR_OUT_W-1:0] color565;
		logic                   last_chunk;
	} chunk_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   m_tlast;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	rect_fill_chunk_generator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	logic [S_TDATA_W-1:0] pending_fills[$];
	chunk_t               expected_chunks[$];
	int                   error_count = 0;
	int                   results_seen = 0;

	// local copy of the screen size and the fill in progress
	int unsigned scr_w = 240;
	int unsigned scr_h = 320;
	bit          fill_busy = 1'b0;
	int unsigned pixels_done = 0;
	int unsigned fill_color, fill_x, fill_w, fill_y, fill_h;

	// sender and receiver pacing
	bit          sender_steady = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	bit          long_hold_req = 1'b0;
	int          hold_left = 0;
	int          pattern_left = 0;
	logic [31:0] stall_pattern = '1;

	task automatic report_error(input string msg);
		if (error_count < 40)
			$display("tb_top: mismatch: %s", msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s got %0h want %0h",
				results_seen, name, got, want));
	endtask

	// expected results of one accepted request word
	task automatic predict_chunks(input logic [S_TDATA_W-1:0] word);
		chunk_t      r;
		int unsigned total, col, row, x1, y1, xlim, ylim, xl, yl, npix;
		int          n;
		n = 0;
		if (!fill_busy) begin
			fill_color = 32'(word[23:0]);
			fill_x = 32'(word[32:24]);
			fill_w = 32'(word[41:33]);
			fill_y = 32'(word[50:42]);
			fill_h = 32'(word[59:51]);
			r = '0;
			r.last_chunk = 1'b1;
			// off-screen takes priority over a zero-area rectangle
			if (fill_x + fill_w > scr_w || fill_y + fill_h > scr_h) begin
				r.status = STAT_REJECT;
				expected_chunks.push_back(r);
				return;
			end
			if (fill_w == 0 || fill_h == 0) begin
				r.status = STAT_EMPTY;
				expected_chunks.push_back(r);
				return;
			end
			fill_busy = 1'b1;
			pixels_done = 0;
		end
		while (fill_busy && n < MAX_RESULTS) begin
			total = fill_w * fill_h;
			col = pixels_done % fill_w;
			row = pixels_done / fill_w;
			x1 = fill_x + col;
			y1 = fill_y + row;
			xlim = (scr_w != 0) ? scr_w - 1 : 0;
			ylim = (scr_h != 0) ? scr_h - 1 : 0;
			xl = x1 + fill_w - 1;
			yl = y1 + fill_h - 1;
			if (xl > xlim)
				xl = xlim;
			if (yl > ylim)
				yl = ylim;
			// mid-row start only finishes the row
			npix = (col != 0) ? fill_w - col : total - pixels_done;
			if (npix > CHUNK_PIXELS_DEF)
				npix = CHUNK_PIXELS_DEF;
			pixels_done += npix;
			if (pixels_done >= total)
				fill_busy = 1'b0;
			r.status = STAT_CHUNK;
			r.x_first = COORD_W'(x1);
			r.x_last = COORD_W'(xl);
			r.y_first = COORD_W'(y1);
			r.y_last = COORD_W'(yl);
			r.pixel_count = PIXCNT_W'(npix);
			r.color565 = COLOR_OUT_W'((((fill_color >> 19) & 32'h1f) << 11)
				| (((fill_color >> 10) & 32'h3f) << 5) | ((fill_color >> 3) & 32'h1f));
			r.last_chunk = !fill_busy;
			expected_chunks.push_back(r);
			n++;
		end
	endtask

	function automatic logic [S_TDATA_W-1:0] make_fill(input logic [23:0] color,
			input logic [8:0] x, input logic [8:0] w, input logic [8:0] y,
			input logic [8:0] h);
		return {4'b0, h, y, w, x, color};
	endfunction

	function automatic int unsigned pick_span(input int unsigned limit);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(1, (limit < 16) ? limit : 16);
		else if (r < 8)
			return $urandom_range(1, limit);
		return $urandom_range((limit > 4) ? limit - 4 : 1, limit);
	endfunction

	// mostly rectangles that fit, plus zero-area, slightly off-screen and raw noise
	function automatic logic [S_TDATA_W-1:0] random_fill();
		int unsigned kind, x, w, y, h;
		kind = $urandom_range(0, 19);
		if (kind == 0)
			return make_fill(COLOR_IN_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom), COORD_W'($urandom));
		w = pick_span(scr_w);
		h = pick_span(scr_h);
		x = $urandom_range(0, scr_w - w);
		y = $urandom_range(0, scr_h - h);
		if (kind == 1) begin
			w = 0;
			x = $urandom_range(0, scr_w);
		end else if (kind == 2) begin
			h = 0;
			y = $urandom_range(0, scr_h);
		end else if (kind == 3) begin
			x = $urandom_range(0, scr_w);
			w = scr_w - x + $urandom_range(1, 3);
		end else if (kind == 4) begin
			y = $urandom_range(0, scr_h);
			h = scr_h - y + $urandom_range(1, 3);
		end
		return make_fill(COLOR_IN_W'($urandom), COORD_W'(x), COORD_W'(w), COORD_W'(y),
			COORD_W'(h));
	endfunction

	// sender: bursts of words with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_chunks(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_fills.size() > 0) begin
					s_tdata <= pending_fills.pop_front();
					s_tvalid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 12);
						if (sender_steady || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 6);
					end
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks results and stalls on a rotating pattern or on a long hold when one is requested
	always @(posedge clk) begin
		chunk_t got, want;
		logic   ready_next;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.x_first = m_tdata[8:0];
				got.x_last = m_tdata[17:9];
				got.y_first = m_tdata[26:18];
				got.y_last = m_tdata[35:27];
				got.pixel_count = m_tdata[48:36];
				got.color565 = m_tdata[64:49];
				got.last_chunk = m_tlast;
				if (expected_chunks.size() == 0)
					report_error($sformatf("unexpected word, status %0d", got.status));
				else begin
					want = expected_chunks.pop_front();
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("win_x_first", 32'(got.x_first), 32'(want.x_first));
					check_field("win_x_last", 32'(got.x_last), 32'(want.x_last));
					check_field("win_y_first", 32'(got.y_first), 32'(want.y_first));
					check_field("win_y_last", 32'(got.y_last), 32'(want.y_last));
					check_field("pixel_count", 32'(got.pixel_count), 32'(want.pixel_count));
					check_field("color_rgb565", 32'(got.color565), 32'(want.color565));
					check_field("last_chunk", 32'(got.last_chunk), 32'(want.last_chunk));
					check_field("pad", 32'(m_tdata[71:65]), 32'd0);
				end
				results_seen++;
			end
			if (long_hold_req && hold_left == 0) begin
				hold_left = 400;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = 64;
					case ($urandom_range(0, 3))
						0: stall_pattern = '1;
						1: stall_pattern = ($urandom & $urandom) | 32'h1;
						default: stall_pattern = $urandom | 32'h1;
					endcase
				end
				pattern_left--;
				ready_next = stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
			end
			m_tready <= ready_next;
		end
	end

	task automatic write_screen_reg(input logic idx, input int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge, then read it back
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_w = value & 32'h1ff;
		else
			scr_h = value & 32'h1ff;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready !== 1'b1 || prdata !== (value & 32'h1ff))
			report_error($sformatf("register %0d read %0h want %0h", idx, prdata,
				value & 32'h1ff));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_fills.size() != 0 || s_tvalid || expected_chunks.size() != 0);
		// allow for the divider and the output stage
		repeat (40) @(posedge clk);
	endtask

	task automatic add_random(input int count);
		repeat (count) pending_fills.push_back(random_fill());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset screen size, 240 x 320
		pending_fills.push_back(make_fill(24'h000000, 0, 0, 0, 0));
		pending_fills.push_back(make_fill(24'hffffff, 0, 0, 5, 10));
		pending_fills.push_back(make_fill(24'h0000ff, 10, 5, 0, 0));
		pending_fills.push_back(make_fill(24'h00ff00, 200, 41, 0, 1));
		pending_fills.push_back(make_fill(24'hff0000, 0, 1, 300, 21));
		pending_fills.push_back(make_fill(24'h808080, 240, 0, 0, 5));
		pending_fills.push_back(make_fill(24'h7f7f7f, 241, 0, 0, 5));
		pending_fills.push_back(make_fill(24'hffffff, 511, 511, 511, 511));
		pending_fills.push_back(make_fill(24'haaaaaa, 0, 1, 0, 1));
		pending_fills.push_back(make_fill(24'h555555, 239, 1, 319, 1));
		pending_fills.push_back(make_fill(24'h123456, 0, 240, 0, 320));
		pending_fills.push_back(make_fill(24'hfedcba, 0, 1, 0, 320));
		pending_fills.push_back(make_fill(24'h0f0f0f, 0, 7, 0, 320));
		pending_fills.push_back(make_fill(24'hf0f0f0, 5, 233, 3, 100));
		pending_fills.push_back(make_fill(24'h3c3c3c, 0, 240, 0, 1));
		pending_fills.push_back(make_fill(24'hc3c3c3, 17, 200, 40, 280));
		add_random(15);
		drain();

		// widest screen, with a long receiver hold while words keep coming
		write_screen_reg(REG_SCREEN_WIDTH, 320);
		write_screen_reg(REG_SCREEN_HEIGHT, 320);
		pending_fills.push_back(make_fill(24'h89abcd, 0, 320, 0, 320));
		pending_fills.push_back(make_fill(24'h010203, 319, 1, 319, 1));
		pending_fills.push_back(make_fill(24'hfffefd, 256, 64, 256, 64));
		pending_fills.push_back(make_fill(24'h6699cc, 300, 20, 100, 220));
		add_random(20);
		sender_steady = 1'b1;
		long_hold_req = 1'b1;
		drain();
		sender_steady = 1'b0;

		write_screen_reg(REG_SCREEN_WIDTH, 1);
		write_screen_reg(REG_SCREEN_HEIGHT, 1);
		add_random(12);
		drain();

		write_screen_reg(REG_SCREEN_HEIGHT, 320);
		add_random(15);
		drain();

		write_screen_reg(REG_SCREEN_WIDTH, 320);
		write_screen_reg(REG_SCREEN_HEIGHT, 1);
		add_random(15);
		drain();

		write_screen_reg(REG_SCREEN_WIDTH, $urandom_range(1, 320));
		write_screen_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 320));
		add_random(20);
		drain();

		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
design/rfc_pkg.sv
design/rfc_queue.sv
design/rfc_front.sv
design/rfc_back.sv
design/rect_fill_chunk_generator.sv
tb/tb_top.sv
